[rtl/core/swps_pkg.sv]
// Shared types and constants for the sliding-window percentile statistics block.
// No dependencies.
package swps_pkg;
   localparam int WINDOW_DEPTH = 64;
   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SCAN_W = $clog2(WINDOW_DEPTH + 1);
   localparam int OUT_CNT_W = 7;
   localparam int WIDE_W = 32;
   localparam int NARROW_W = 16;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one sample as it travels along the cell row
   typedef struct packed {
      logic [WIDE_W-1:0] uptime;
      logic [WIDE_W-1:0] heap;
      logic [NARROW_W-1:0] rate;
      logic [NARROW_W-1:0] agents;
   } sample_type;

   // per-cell controls: clear goes to every cell, load to cell 0, shift to the rest
   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } cell_ctrl_type;

   // rank index floor(p*(n-1)/100); n-1 fits in 8 bits, product in 15
   function automatic logic [CNT_W-1:0] rank_index(input logic [CNT_W-1:0] n,
                                                   input logic [6:0] p);
      logic [15:0] prod;
      logic [15:0] q;
      begin
         prod = 16'(p) * 16'(n - CNT_W'(1));
         // divide by 100 through multiply by reciprocal: exact for prod < 2^16
         q = 16'((32'(prod) * 32'd41944) >> 22);
         if (32'(q) * 32'd100 > 32'(prod)) q = q - 16'd1;
         rank_index = CNT_W'(q);
      end
   endfunction
endpackage

[rtl/core/swps_cell.sv]
// One cell of the window shift row: holds one sample and a valid bit, and
// counts how many valid samples rank below its own value for each field.
// Depends on swps_pkg.
module swps_cell (
   input logic clock,
   input logic reset,
   input swps_pkg::cell_ctrl_type ctrl,
   input swps_pkg::sample_type load_data,
   input logic load_valid,
   input swps_pkg::sample_type left_data,
   input logic left_valid,
   input swps_pkg::sample_type probe,
   input logic probe_valid,
   input logic [swps_pkg::SCAN_W-1:0] probe_pos,
   input logic [swps_pkg::SCAN_W-1:0] own_pos,
   output swps_pkg::sample_type data,
   output logic valid,
   output logic [swps_pkg::SCAN_W-1:0] heap_rank,
   output logic [swps_pkg::SCAN_W-1:0] rate_rank,
   output logic [swps_pkg::SCAN_W-1:0] agents_rank
);
   import swps_pkg::*;

   sample_type data_ff, data_in;
   logic valid_ff, valid_in;
   logic [SCAN_W-1:0] hr_ff, hr_in, rr_ff, rr_in, ar_ff, ar_in;
   logic before_me;

   // ties broken by position so ranks are a permutation
   assign before_me = probe_pos < own_pos;

   always_comb begin
      data_in = data_ff;
      valid_in = valid_ff;
      hr_in = hr_ff;
      rr_in = rr_ff;
      ar_in = ar_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.load) begin
         data_in = load_data;
         valid_in = load_valid;
         hr_in = '0;
         rr_in = '0;
         ar_in = '0;
      end else if (ctrl.shift) begin
         data_in = left_data;
         valid_in = left_valid;
         hr_in = '0;
         rr_in = '0;
         ar_in = '0;
      end else if (probe_valid) begin
         if (probe.heap < data_ff.heap || (probe.heap == data_ff.heap && before_me))
            hr_in = hr_ff + SCAN_W'(1);
         if (probe.rate < data_ff.rate || (probe.rate == data_ff.rate && before_me))
            rr_in = rr_ff + SCAN_W'(1);
         if (probe.agents < data_ff.agents ||
             (probe.agents == data_ff.agents && before_me))
            ar_in = ar_ff + SCAN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      hr_ff <= hr_in;
      rr_ff <= rr_in;
      ar_ff <= ar_in;
   end

   assign data = data_ff;
   assign valid = valid_ff;
   assign heap_rank = hr_ff;
   assign rate_rank = rr_ff;
   assign agents_rank = ar_ff;
endmodule

[rtl/core/sliding_window_percentile_stats_top.sv]
// Sliding-window percentile statistics: the window is a row of cells that
// shifts a new sample in at cell 0, the oldest falling off the far end.
// Each transaction runs a rank pass, in which every sample is broadcast in turn to
// all cells, then a selection pass over the row.
// One transaction at a time: new requests are stalled until the response is taken.
// Reset (synchronous, active high) empties the window and idles the sequencer.
module sliding_window_percentile_stats_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic req_op,
   input logic [31:0] req_uptime_ms,
   input logic [31:0] req_heap_free,
   input logic [15:0] req_frame_rate,
   input logic [15:0] req_agent_count,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic rsp_valid_res,
   output logic [6:0] rsp_sample_count,
   output logic [31:0] rsp_heap_min,
   output logic [31:0] rsp_heap_median,
   output logic [15:0] rsp_rate_median,
   output logic [15:0] rsp_rate_low_pct,
   output logic [15:0] rsp_agents_median,
   output logic [15:0] rsp_agents_high_pct,
   output logic [31:0] rsp_uptime_min,
   output logic [31:0] rsp_uptime_max
);
   import swps_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in; // 0 rank pass, 1 select pass
   logic [SCAN_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   cell_ctrl_type ctrl;
   logic accept, done_scan;

   sample_type cdata [WINDOW_DEPTH];
   logic cvalid [WINDOW_DEPTH];
   logic [SCAN_W-1:0] hrank [WINDOW_DEPTH];
   logic [SCAN_W-1:0] rrank [WINDOW_DEPTH];
   logic [SCAN_W-1:0] arank [WINDOW_DEPTH];
   sample_type req_sample, probe;
   logic probe_valid;

   logic [CNT_W-1:0] k_med, k_lo, k_hi;
   logic [31:0] heap_min_ff, heap_med_ff, umin_ff, umax_ff;
   logic [15:0] rmed_ff, rlo_ff, amed_ff, ahi_ff;
   logic [31:0] heap_min_in, heap_med_in, umin_in, umax_in;
   logic [15:0] rmed_in, rlo_in, amed_in, ahi_in;

   assign req_sample = '{uptime: req_uptime_ms, heap: req_heap_free,
                         rate: req_frame_rate, agents: req_agent_count};
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // cell row: on a record, cell 0 loads, the rest shift right
   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      cell_ctrl_type cc;
      assign cc.clear = accept && req_op == OP_CLEAR;
      assign cc.load = (g == 0) && accept && req_op == OP_RECORD;
      assign cc.shift = (g != 0) && accept && req_op == OP_RECORD;
      swps_cell u_cell (
         .clock(clock), .reset(reset), .ctrl(cc),
         .load_data(req_sample), .load_valid(1'b1),
         .left_data(cdata[(g == 0) ? 0 : g-1]), .left_valid(cvalid[(g == 0) ? 0 : g-1]),
         .probe(probe), .probe_valid(probe_valid),
         .probe_pos(idx_ff), .own_pos(SCAN_W'(g)),
         .data(cdata[g]), .valid(cvalid[g]),
         .heap_rank(hrank[g]), .rate_rank(rrank[g]), .agents_rank(arank[g])
      );
   end

   logic [PTR_W-1:0] sel;
   assign sel = idx_ff[PTR_W-1:0];
   assign probe = cdata[sel];
   assign probe_valid = (state_ff == ST_SCAN) && (phase_ff == 2'd0) &&
                        (idx_ff < SCAN_W'(WINDOW_DEPTH)) && cvalid[sel];
   assign done_scan = idx_ff == SCAN_W'(WINDOW_DEPTH - 1);

   assign k_med = rank_index(fill_ff, 7'd50);
   assign k_lo = rank_index(fill_ff, 7'd5);
   assign k_hi = rank_index(fill_ff, 7'd95);

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_op == OP_CLEAR) fill_in = '0;
         else if (fill_ff < CNT_W'(WINDOW_DEPTH)) fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SCAN;
         ST_SCAN: if (phase_ff == 2'd1 && done_scan) state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      if (state_ff == ST_IDLE) begin
         phase_in = 2'd0;
         idx_in = '0;
      end else if (state_ff == ST_SCAN) begin
         if (done_scan) begin
            phase_in = 2'd1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + SCAN_W'(1);
         end
      end
   end

   // select pass: each cell is visited once, its ranks matched and uptime min/max tracked
   always_comb begin
      heap_min_in = heap_min_ff;
      heap_med_in = heap_med_ff;
      umin_in = umin_ff;
      umax_in = umax_ff;
      rmed_in = rmed_ff;
      rlo_in = rlo_ff;
      amed_in = amed_ff;
      ahi_in = ahi_ff;
      if (state_ff == ST_IDLE) begin
         heap_min_in = '0; heap_med_in = '0; umin_in = '0; umax_in = '0;
         rmed_in = '0; rlo_in = '0; amed_in = '0; ahi_in = '0;
      end else if (state_ff == ST_SCAN && phase_ff == 2'd1 && cvalid[sel]) begin
         if (hrank[sel] == '0) heap_min_in = cdata[sel].heap;
         if (hrank[sel] == SCAN_W'(k_med)) heap_med_in = cdata[sel].heap;
         if (rrank[sel] == SCAN_W'(k_med)) rmed_in = cdata[sel].rate;
         if (rrank[sel] == SCAN_W'(k_lo)) rlo_in = cdata[sel].rate;
         if (arank[sel] == SCAN_W'(k_med)) amed_in = cdata[sel].agents;
         if (arank[sel] == SCAN_W'(k_hi)) ahi_in = cdata[sel].agents;
         if (idx_ff == '0 || cdata[sel].uptime < umin_ff) umin_in = cdata[sel].uptime;
         if (idx_ff == '0 || cdata[sel].uptime > umax_ff) umax_in = cdata[sel].uptime;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         phase_ff <= 2'd0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         phase_ff <= phase_in;
         idx_ff <= idx_in;
      end
      heap_min_ff <= heap_min_in;
      heap_med_ff <= heap_med_in;
      umin_ff <= umin_in;
      umax_ff <= umax_in;
      rmed_ff <= rmed_in;
      rlo_ff <= rlo_in;
      amed_ff <= amed_in;
      ahi_ff <= ahi_in;
   end

   always_comb begin
      rsp_valid = (state_ff == ST_DONE);
      rsp_valid_res = (fill_ff != '0);
      rsp_sample_count = OUT_CNT_W'(fill_ff);
      rsp_heap_min = heap_min_ff;
      rsp_heap_median = heap_med_ff;
      rsp_rate_median = rmed_ff;
      rsp_rate_low_pct = rlo_ff;
      rsp_agents_median = amed_ff;
      rsp_agents_high_pct = ahi_ff;
      rsp_uptime_min = umin_ff;
      rsp_uptime_max = umax_ff;
   end
endmodule

[rtl/core/swps_checker.sv]
// Port-level checker for the sliding-window statistics top level, bound in below.
// Depends on the top level's ports only.
module swps_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_valid_res,
   input logic [6:0] rsp_sample_count
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_count))
      else $error("response dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   a_valid_res: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_res == (rsp_sample_count != 7'd0)))
      else $error("valid_res disagrees with count");
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response too early");
endmodule

bind sliding_window_percentile_stats_top swps_checker u_swps_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_valid_res(rsp_valid_res),
   .rsp_sample_count(rsp_sample_count)
);

[test/sliding_window_percentile_stats_top_test.sv]
// Self-checking testbench for sliding_window_percentile_stats_top: directed and random
// record/clear traffic, with a local window predictor checked against every response.
// Depends on swps_pkg and the RTL top level.
`timescale 1ns / 100ps

module sliding_window_percentile_stats_top_test;
   import swps_pkg::*;

   typedef struct {
      logic valid_res;
      logic [6:0] count;
      logic [31:0] heap_min, heap_med;
      logic [15:0] rate_med, rate_low;
      logic [15:0] agents_med, agents_high;
      logic [31:0] up_min, up_max;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = OP_RECORD;
   logic [31:0] req_uptime_ms = '0, req_heap_free = '0;
   logic [15:0] req_frame_rate = '0, req_agent_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_valid_res;
   logic [6:0] rsp_sample_count;
   logic [31:0] rsp_heap_min, rsp_heap_median, rsp_uptime_min, rsp_uptime_max;
   logic [15:0] rsp_rate_median, rsp_rate_low_pct, rsp_agents_median, rsp_agents_high_pct;

   sliding_window_percentile_stats_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // window predictor state
   logic [31:0] win_uptime[WINDOW_DEPTH];
   logic [31:0] win_heap[WINDOW_DEPTH];
   logic [15:0] win_rate[WINDOW_DEPTH];
   logic [15:0] win_agents[WINDOW_DEPTH];
   int wr_slot = 0;
   int fill = 0;

   stats_type pending_stats[$];
   int error_count = 0;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   int hold_cycles = 0;

   function automatic int rank_pos(int n, int p);
      return (p * (n - 1)) / 100;
   endfunction

   function automatic stats_type window_stats(logic op, logic [31:0] up, logic [31:0] heap,
                                              logic [15:0] rate, logic [15:0] agents);
      stats_type s;
      logic [31:0] hs[$];
      logic [15:0] rs[$], as_[$];
      if (op == OP_CLEAR) begin
         wr_slot = 0;
         fill = 0;
      end else begin
         win_uptime[wr_slot] = up;
         win_heap[wr_slot] = heap;
         win_rate[wr_slot] = rate;
         win_agents[wr_slot] = agents;
         wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
         if (fill < WINDOW_DEPTH) fill++;
      end
      s = '{default: '0};
      if (fill == 0) return s;
      s.valid_res = 1'b1;
      s.count = 7'(fill);
      s.up_min = win_uptime[0];
      s.up_max = win_uptime[0];
      for (int i = 0; i < fill; i++) begin
         hs.push_back(win_heap[i]);
         rs.push_back(win_rate[i]);
         as_.push_back(win_agents[i]);
         if (win_uptime[i] < s.up_min) s.up_min = win_uptime[i];
         if (win_uptime[i] > s.up_max) s.up_max = win_uptime[i];
      end
      hs.sort();
      rs.sort();
      as_.sort();
      s.heap_min = hs[0];
      s.heap_med = hs[rank_pos(fill, 50)];
      s.rate_med = rs[rank_pos(fill, 50)];
      s.rate_low = rs[rank_pos(fill, 5)];
      s.agents_med = as_[rank_pos(fill, 50)];
      s.agents_high = as_[rank_pos(fill, 95)];
      return s;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0h expected %0h (window %0d)", what, got, want, fill);
      error_count++;
   endtask

   // one transaction: drive at the falling edge, hold until accepted; valid is
   // left high on return and dropped by the next idle cycle or at the end
   task automatic send_sample(logic op, logic [31:0] up, logic [31:0] heap,
                              logic [15:0] rate, logic [15:0] agents);
      while (send_gaps && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_uptime_ms <= up;
      req_heap_free <= heap;
      req_frame_rate <= rate;
      req_agent_count <= agents;
      do @(posedge clock); while (req_stall);
      pending_stats.push_back(window_stats(op, up, heap, rate, agents));
      @(negedge clock);
   endtask

   task automatic send_clear_random();
      send_sample(OP_CLEAR, $urandom, $urandom, 16'($urandom), 16'($urandom));
   endtask

   task automatic record_random(int spread);
      logic [31:0] up, heap;
      logic [15:0] rate, agents;
      up = $urandom;
      heap = $urandom;
      rate = 16'($urandom);
      agents = 16'($urandom);
      if (spread == 1) begin
         heap = $urandom_range(7);
         rate = 16'($urandom_range(3));
         agents = 16'hFFFF - 16'($urandom_range(3));
      end
      send_sample(OP_RECORD, up, heap, rate, agents);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= recv_gaps && ($urandom_range(99) < 12);
   end

   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
         end else begin
            e = pending_stats.pop_front();
            if (rsp_valid_res !== e.valid_res)
               report_mismatch("valid_res", rsp_valid_res, e.valid_res);
            if (rsp_sample_count !== e.count)
               report_mismatch("sample_count", rsp_sample_count, e.count);
            if (rsp_heap_min !== e.heap_min) report_mismatch("heap_min", rsp_heap_min, e.heap_min);
            if (rsp_heap_median !== e.heap_med)
               report_mismatch("heap_median", rsp_heap_median, e.heap_med);
            if (rsp_rate_median !== e.rate_med)
               report_mismatch("rate_median", rsp_rate_median, e.rate_med);
            if (rsp_rate_low_pct !== e.rate_low)
               report_mismatch("rate_low_pct", rsp_rate_low_pct, e.rate_low);
            if (rsp_agents_median !== e.agents_med)
               report_mismatch("agents_median", rsp_agents_median, e.agents_med);
            if (rsp_agents_high_pct !== e.agents_high)
               report_mismatch("agents_high_pct", rsp_agents_high_pct, e.agents_high);
            if (rsp_uptime_min !== e.up_min)
               report_mismatch("uptime_min", rsp_uptime_min, e.up_min);
            if (rsp_uptime_max !== e.up_max)
               report_mismatch("uptime_max", rsp_uptime_max, e.up_max);
         end
      end
   end

   task automatic test_directed();
      send_sample(OP_CLEAR, '1, '1, '1, '1);  // clear on an empty window
      send_sample(OP_RECORD, '0, '0, '0, '0);
      send_sample(OP_RECORD, '1, '1, '1, '1);
      send_sample(OP_RECORD, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF);
      send_sample(OP_RECORD, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
      send_sample(OP_CLEAR, '0, '0, '0, '0);
      send_sample(OP_RECORD, 32'd1000, 32'd5, 16'd60, 16'd3);
      send_sample(OP_RECORD, 32'd1000, 32'd5, 16'd60, 16'd3);  // duplicates
      send_sample(OP_CLEAR, '0, '0, '0, '0);
   endtask

   // fill past the depth so the oldest entries are overwritten and the slot wraps
   task automatic test_wrap();
      for (int i = 0; i < 2 * WINDOW_DEPTH + 5; i++) record_random(i % 2);
      send_clear_random();
   endtask

   task automatic test_backpressure();
      hold_cycles = 600;
      for (int i = 0; i < 12; i++) record_random(0);
   endtask

   task automatic test_random(int items);
      for (int i = 0; i < items; i++) begin
         send_gaps = !(i >= 300 && i < 450);
         recv_gaps = send_gaps;
         if ($urandom_range(99) < 2) send_clear_random();
         else record_random($urandom_range(2));
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_wrap();
      test_backpressure();
      test_random(1000);
      req_valid <= 1'b0;
      wait (pending_stats.size() == 0);
      repeat (2 * WINDOW_DEPTH + 10) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // timeout sized for ~1200 transactions, with margin
   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
